[rtl/core/tps_pkg.sv]
`default_nettype none

package tps_pkg;

   // Axis count and configuration register map
   localparam int NUM_AXES  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HOME_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd3;

   localparam logic [8:0] GAIN_RESET = 9'd102;
   localparam logic [8:0] GAIN_FULL  = 9'd256;

   // Raw clamp limits in micrometers
   localparam logic [15:0] X_LIMIT  = 16'd35000;
   localparam logic [15:0] YZ_LIMIT = 16'd50000;

   // Scale to Q8.8 percent: X is mag*128/175, Y and Z are mag*64/125.
   // Exact floor by reciprocal since mag stays below 2^SCALE_SHIFT / 175.
   localparam int SCALE_SHIFT = 24;
   localparam logic [23:0] X_RECIP  = 24'(((64'd1 << 31) + 64'd174) / 64'd175);
   localparam logic [23:0] YZ_RECIP = 24'(((64'd1 << 30) + 64'd124) / 64'd125);

   // +/-100.0 percent in Q8.8
   localparam logic signed [16:0] PCT_POS = 17'sd25600;
   localparam logic signed [16:0] PCT_NEG = -17'sd25600;

   // CORDIC datapath
   localparam int CORDIC_W    = 26;
   localparam int PRESCALE    = 8;
   localparam int ATAN_IDX_W  = 5;
   localparam logic [15:0] ANGLE_PI = 16'h8000;

   typedef struct packed {
      logic ld_in;
      logic scale;
      logic cond;
      logic mult;
      logic filt;
      logic cinit;
      logic citer;
      logic load_out;
   } tps_cmd_type;

   // round(atan(2^-i) * 32768 / pi)
   function automatic logic [15:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'd8192;
         5'd1:    val = 16'd4836;
         5'd2:    val = 16'd2555;
         5'd3:    val = 16'd1297;
         5'd4:    val = 16'd651;
         5'd5:    val = 16'd326;
         5'd6:    val = 16'd163;
         5'd7:    val = 16'd81;
         5'd8:    val = 16'd41;
         5'd9:    val = 16'd20;
         5'd10:   val = 16'd10;
         5'd11:   val = 16'd5;
         5'd12:   val = 16'd3;
         5'd13:   val = 16'd1;
         5'd14:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[rtl/core/three_axis_position_smoother.sv]
// Channel   Handshake             Payload
// request   req_valid/req_stall   req_raw_x, req_raw_y, req_raw_z
// result    rsp_valid/rsp_stall   rsp_smooth_*, rsp_delta_*, rsp_pitch_angle,
//                                 rsp_yaw_angle
// config    csr_we                csr_index, csr_wdata (no read-back)
//
// One request at a time: the next request is taken only after the scale,
// offset/clamp, filter multiply and filter sum states, the CORDIC load, the
// CORDIC iterations (one per cycle, both angles in parallel), the result
// load and the return to the idle state that takes the next request.
// Synchronous active-high reset: offsets 0, gain 102, filter history 0.
// A held result does not block the pipe until the next one is ready to load;
// req_stall is high from acceptance until the result register is loaded.
`default_nettype none

module three_axis_position_smoother #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [16:0]             req_raw_x,
   input  wire logic signed [16:0]             req_raw_y,
   input  wire logic signed [16:0]             req_raw_z,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [15:0]                  rsp_smooth_x,
   output logic signed [15:0]                  rsp_smooth_y,
   output logic signed [15:0]                  rsp_smooth_z,
   output logic signed [16:0]                  rsp_delta_x,
   output logic signed [16:0]                  rsp_delta_y,
   output logic signed [16:0]                  rsp_delta_z,
   output logic signed [15:0]                  rsp_pitch_angle,
   output logic signed [15:0]                  rsp_yaw_angle,
   // configuration write port
   input  wire logic                           csr_we,
   input  wire logic [tps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tps_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import tps_pkg::*;

   tps_cmd_type                        cmd;
   logic [$clog2(CORDIC_STEPS)-1:0]    step;

   // Sequencer: walks scale, offset/clamp, filter multiply, filter sum,
   // CORDIC load and the iterations, then loads the result register.
   tps_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .step      (step)
   );

   // Datapath: clamp and scale, home offset, low-pass with history,
   // two CORDIC vectoring units, result register and config registers.
   tps_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .step            (step),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_raw_z       (req_raw_z),
      .rsp_smooth_x    (rsp_smooth_x),
      .rsp_smooth_y    (rsp_smooth_y),
      .rsp_smooth_z    (rsp_smooth_z),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_delta_z     (rsp_delta_z),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

endmodule

`default_nettype wire

[rtl/core/tps_cordic.sv]
`default_nettype none

module tps_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              start,
   input  wire logic                              advance,
   input  wire logic [$clog2(CORDIC_STEPS)-1:0]   step,
   input  wire logic signed [15:0]                x_in,
   input  wire logic signed [15:0]                y_in,
   output logic signed [15:0]                     angle
);
   import tps_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in_next;
   logic signed [CORDIC_W-1:0] y_ff, y_in_next;
   logic [15:0]                z_ff, z_in;
   logic                       zero_ff, zero_in;

   logic signed [16:0]         xn, yn;
   logic signed [CORDIC_W-1:0] x_ext, y_ext, xs, ys;
   logic [15:0]                atan_val;
   logic                       neg;

   always_comb begin
      neg       = x_in[15];
      xn        = neg ? -{x_in[15], x_in} : {x_in[15], x_in};
      yn        = neg ? -{y_in[15], y_in} : {y_in[15], y_in};
      x_ext     = CORDIC_W'(xn);
      y_ext     = CORDIC_W'(yn);
      xs        = x_ff >>> step;
      ys        = y_ff >>> step;
      atan_val  = atan_entry(ATAN_IDX_W'(step));
      x_in_next = x_ff;
      y_in_next = y_ff;
      z_in      = z_ff;
      zero_in   = zero_ff;
      if (start) begin
         // fold the left half plane onto the right one, start at pi
         x_in_next = x_ext <<< PRESCALE;
         y_in_next = y_ext <<< PRESCALE;
         z_in      = neg ? ANGLE_PI : 16'd0;
         zero_in   = (x_in == 16'sd0) && (y_in == 16'sd0);
      end else if (advance) begin
         if (!y_ff[CORDIC_W-1]) begin
            x_in_next = x_ff + ys;
            y_in_next = y_ff - xs;
            z_in      = z_ff + atan_val;
         end else begin
            x_in_next = x_ff - ys;
            y_in_next = y_ff + xs;
            z_in      = z_ff - atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_next;
      y_ff    <= y_in_next;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   assign angle = zero_ff ? 16'sd0 : $signed(z_ff);

endmodule

`default_nettype wire

[rtl/core/tps_ctrl.sv]
`default_nettype none

module tps_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output tps_pkg::tps_cmd_type                  cmd,
   output logic [$clog2(CORDIC_STEPS)-1:0]       step
);
   import tps_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_COND  = 3'd2;
   localparam logic [2:0] ST_MULT  = 3'd3;
   localparam logic [2:0] ST_FILT  = 3'd4;
   localparam logic [2:0] ST_CINIT = 3'd5;
   localparam logic [2:0] ST_ITER  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.ld_in = 1'b1;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_COND;
         end
         ST_COND: begin
            cmd.cond = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            cmd.cinit = 1'b1;
            step_in   = '0;
            state_in  = ST_ITER;
         end
         ST_ITER: begin
            cmd.citer = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign step      = step_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !cmd.load_out))
      else $error("request taken without going busy");

   a_loaded_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (step_ff <= LAST_STEP))
      else $error("CORDIC step out of range");

endmodule

`default_nettype wire

[rtl/core/tps_datapath.sv]
`default_nettype none

module tps_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tps_pkg::tps_cmd_type               cmd,
   input  wire logic [$clog2(CORDIC_STEPS)-1:0]    step,
   input  wire logic                               csr_we,
   input  wire logic [tps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tps_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  wire logic signed [16:0]                 req_raw_x,
   input  wire logic signed [16:0]                 req_raw_y,
   input  wire logic signed [16:0]                 req_raw_z,
   output logic signed [15:0]                      rsp_smooth_x,
   output logic signed [15:0]                      rsp_smooth_y,
   output logic signed [15:0]                      rsp_smooth_z,
   output logic signed [16:0]                      rsp_delta_x,
   output logic signed [16:0]                      rsp_delta_y,
   output logic signed [16:0]                      rsp_delta_z,
   output logic signed [15:0]                      rsp_pitch_angle,
   output logic signed [15:0]                      rsp_yaw_angle
);
   import tps_pkg::*;

   function automatic logic [15:0] clamp_mag(input logic signed [16:0] raw,
                                             input logic [15:0] lim);
      logic signed [17:0] wide;
      logic [17:0]        mag;
      wide = {raw[16], raw};
      mag  = wide[17] ? 18'(-wide) : 18'(wide);
      return (mag > {2'b00, lim}) ? lim : mag[15:0];
   endfunction

   logic signed [16:0] raw_a [NUM_AXES];

   // configuration and filter history
   logic signed [15:0] home_ff [NUM_AXES];
   logic [8:0]         gain_ff, gain_in;
   logic signed [15:0] prev_ff [NUM_AXES];

   // per-item working registers
   logic [15:0]        mag_ff   [NUM_AXES], mag_in   [NUM_AXES];
   logic [NUM_AXES-1:0] neg_ff, neg_in;
   logic signed [15:0] q_ff     [NUM_AXES], q_in     [NUM_AXES];
   logic signed [15:0] s_ff     [NUM_AXES], s_in     [NUM_AXES];
   logic signed [25:0] pa_ff    [NUM_AXES], pa_in    [NUM_AXES];
   logic signed [25:0] pb_ff    [NUM_AXES], pb_in    [NUM_AXES];
   logic signed [15:0] f_ff     [NUM_AXES], f_in     [NUM_AXES];
   logic signed [16:0] dlt_ff   [NUM_AXES], dlt_in   [NUM_AXES];

   // result register
   logic signed [15:0] out_f_ff [NUM_AXES];
   logic signed [16:0] out_d_ff [NUM_AXES];
   logic signed [15:0] out_pitch_ff, out_yaw_ff;
   logic signed [15:0] pitch_val, yaw_val;

   logic [39:0]        prod     [NUM_AXES];
   logic signed [16:0] qs       [NUM_AXES];
   logic signed [16:0] diff     [NUM_AXES];
   logic signed [26:0] acc      [NUM_AXES];
   logic signed [9:0]  g_s, inv_s;

   assign raw_a[0] = req_raw_x;
   assign raw_a[1] = req_raw_y;
   assign raw_a[2] = req_raw_z;

   assign gain_in = (csr_wdata[8:0] > GAIN_FULL) ? GAIN_FULL : csr_wdata[8:0];
   assign g_s     = $signed({1'b0, gain_ff});
   assign inv_s   = $signed(10'd256 - {1'b0, gain_ff});

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         mag_in[a] = clamp_mag(raw_a[a], (a == 0) ? X_LIMIT : YZ_LIMIT);
         neg_in[a] = raw_a[a][16];

         prod[a] = 40'(mag_ff[a]) * 40'((a == 0) ? X_RECIP : YZ_RECIP);
         qs[a]   = $signed({1'b0, prod[a][SCALE_SHIFT +: 16]});
         q_in[a] = neg_ff[a] ? 16'(-qs[a]) : 16'(qs[a]);

         diff[a] = {q_ff[a][15], q_ff[a]} - {home_ff[a][15], home_ff[a]};
         if (diff[a] > PCT_POS) begin
            s_in[a] = PCT_POS[15:0];
         end else if (diff[a] < PCT_NEG) begin
            s_in[a] = PCT_NEG[15:0];
         end else begin
            s_in[a] = diff[a][15:0];
         end

         pa_in[a] = g_s * s_ff[a];
         pb_in[a] = inv_s * prev_ff[a];

         // arithmetic shift by 8 floors the weighted sum
         acc[a]    = {pa_ff[a][25], pa_ff[a]} + {pb_ff[a][25], pb_ff[a]};
         f_in[a]   = acc[a][23:8];
         dlt_in[a] = {f_in[a][15], f_in[a]} - {prev_ff[a][15], prev_ff[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            home_ff[a] <= '0;
            prev_ff[a] <= '0;
         end
         gain_ff <= GAIN_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HOME_X: home_ff[0] <= $signed(csr_wdata);
               CSR_HOME_Y: home_ff[1] <= $signed(csr_wdata);
               CSR_HOME_Z: home_ff[2] <= $signed(csr_wdata);
               CSR_GAIN:   gain_ff    <= gain_in;
               default:    gain_ff    <= gain_ff;
            endcase
         end
         if (cmd.filt) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               prev_ff[a] <= f_in[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (cmd.ld_in) begin
            mag_ff[a] <= mag_in[a];
            neg_ff[a] <= neg_in[a];
         end
         if (cmd.scale) begin
            q_ff[a] <= q_in[a];
         end
         if (cmd.cond) begin
            s_ff[a] <= s_in[a];
         end
         if (cmd.mult) begin
            pa_ff[a] <= pa_in[a];
            pb_ff[a] <= pb_in[a];
         end
         if (cmd.filt) begin
            f_ff[a]   <= f_in[a];
            dlt_ff[a] <= dlt_in[a];
         end
         if (cmd.load_out) begin
            out_f_ff[a] <= f_ff[a];
            out_d_ff[a] <= dlt_ff[a];
         end
      end
      if (cmd.load_out) begin
         out_pitch_ff <= pitch_val;
         out_yaw_ff   <= yaw_val;
      end
   end

   tps_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_pitch (
      .clock   (clock),
      .start   (cmd.cinit),
      .advance (cmd.citer),
      .step    (step),
      .x_in    (f_ff[0]),
      .y_in    (f_ff[2]),
      .angle   (pitch_val)
   );

   tps_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_yaw (
      .clock   (clock),
      .start   (cmd.cinit),
      .advance (cmd.citer),
      .step    (step),
      .x_in    (f_ff[0]),
      .y_in    (f_ff[1]),
      .angle   (yaw_val)
   );

   assign rsp_smooth_x    = out_f_ff[0];
   assign rsp_smooth_y    = out_f_ff[1];
   assign rsp_smooth_z    = out_f_ff[2];
   assign rsp_delta_x     = out_d_ff[0];
   assign rsp_delta_y     = out_d_ff[1];
   assign rsp_delta_z     = out_d_ff[2];
   assign rsp_pitch_angle = out_pitch_ff;
   assign rsp_yaw_angle   = out_yaw_ff;

endmodule

`default_nettype wire

[tb/tb_three_axis_position_smoother.sv]
`timescale 1ns / 1ps

module tb_three_axis_position_smoother;
   import tps_pkg::*;

   localparam int CORDIC_STEPS  = 16;
   localparam int IDLE_MAX      = 18;
   localparam int SETTLE_CYCLES = CORDIC_STEPS + 10;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 158;

   // Binary-angle arctangent steps, round(atan(2^-i) * 32768 / pi)
   localparam int ATAN_LUT [0:23] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1, 1, 0,
                                      0, 0, 0, 0, 0, 0, 0, 0};

   typedef struct packed {
      logic signed [15:0] smooth_x;
      logic signed [15:0] smooth_y;
      logic signed [15:0] smooth_z;
      logic signed [16:0] delta_x;
      logic signed [16:0] delta_y;
      logic signed [16:0] delta_z;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } pose_type;

   typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_type;

   // One line of the directed plan: either a register write or a request
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DAT_W-1:0]   data;
      logic signed [16:0]     rx;
      logic signed [16:0]     ry;
      logic signed [16:0]     rz;
      logic                   typed;
      pose_type               want;
   } row_type;

   // Block interface
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [16:0]   req_raw_x = '0;
   logic signed [16:0]   req_raw_y = '0;
   logic signed [16:0]   req_raw_z = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [15:0]   rsp_smooth_x;
   logic signed [15:0]   rsp_smooth_y;
   logic signed [15:0]   rsp_smooth_z;
   logic signed [16:0]   rsp_delta_x;
   logic signed [16:0]   rsp_delta_y;
   logic signed [16:0]   rsp_delta_z;
   logic signed [15:0]   rsp_pitch_angle;
   logic signed [15:0]   rsp_yaw_angle;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Shadow of the block's registers and filter history
   int home_x = 0;
   int home_y = 0;
   int home_z = 0;
   int gain   = int'(GAIN_RESET);
   int prev_x = 0;
   int prev_y = 0;
   int prev_z = 0;

   pose_type pending_poses[$];
   row_type  plan[$];
   bit       pending_typed = 1'b0;
   pose_type pending_want  = '0;
   bit       no_idle       = 1'b0;
   int       error_count   = 0;

   three_axis_position_smoother #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_raw_z       (req_raw_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_smooth_x    (rsp_smooth_x),
      .rsp_smooth_y    (rsp_smooth_y),
      .rsp_smooth_z    (rsp_smooth_z),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_delta_z     (rsp_delta_z),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   function automatic int clamp_to(int v, int lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   // Clamp the raw micrometers, scale to Q8.8 percent (truncate toward
   // zero), remove the home offset and clamp to +/-100 percent.
   function automatic int condition_axis(int raw, int lim, int home);
      int c;
      int mag;
      int q;
      c   = clamp_to(raw, lim);
      mag = (c < 0) ? -c : c;
      q   = int'((longint'(mag) * 25600) / lim);
      if (c < 0)
         q = -q;
      return clamp_to(q - home, int'(PCT_POS));
   endfunction

   // First-order low-pass; the arithmetic shift gives the floor
   function automatic int lowpass_axis(int s, int prev);
      int acc;
      acc = gain * s + (256 - gain) * prev;
      return acc >>> 8;
   endfunction

   // Vectoring CORDIC on operands prescaled by 256
   function automatic logic [15:0] cordic_angle(int y, int x);
      int acc;
      int xs;
      int ys;
      acc = 0;
      if (x == 0 && y == 0)
         return 16'd0;
      // Rotate a left-half vector by pi and seed the accumulator with +/-pi
      if (x < 0) begin
         acc = (y >= 0) ? 32768 : -32768;
         x   = -x;
         y   = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x   = x + ys;
            y   = y - xs;
            acc = acc + ATAN_LUT[i];
         end else begin
            x   = x - ys;
            y   = y + xs;
            acc = acc - ATAN_LUT[i];
         end
      end
      return acc[15:0];
   endfunction

   // Work out the result of one request and advance the filter history
   function automatic pose_type predict_pose(logic signed [16:0] rx, logic signed [16:0] ry,
                                             logic signed [16:0] rz);
      int       fx;
      int       fy;
      int       fz;
      pose_type p;
      fx = lowpass_axis(condition_axis(rx, int'(X_LIMIT), home_x), prev_x);
      fy = lowpass_axis(condition_axis(ry, int'(YZ_LIMIT), home_y), prev_y);
      fz = lowpass_axis(condition_axis(rz, int'(YZ_LIMIT), home_z), prev_z);
      p.smooth_x = 16'(fx);
      p.smooth_y = 16'(fy);
      p.smooth_z = 16'(fz);
      p.delta_x  = 17'(fx - prev_x);
      p.delta_y  = 17'(fy - prev_y);
      p.delta_z  = 17'(fz - prev_z);
      p.pitch    = cordic_angle(fz, fx);
      p.yaw      = cordic_angle(fy, fx);
      prev_x = fx;
      prev_y = fy;
      prev_z = fz;
      return p;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DAT_W-1:0] data);
      case (idx)
         CSR_HOME_X: home_x = int'($signed(data));
         CSR_HOME_Y: home_y = int'($signed(data));
         CSR_HOME_Z: home_z = int'($signed(data));
         CSR_GAIN: begin
            // Only nine bits are kept, and anything past unity saturates
            gain = int'(data[8:0]);
            if (gain > int'(GAIN_FULL))
               gain = int'(GAIN_FULL);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_error(string msg);
      $display("[%0t] %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic signed [31:0] got,
                              logic signed [31:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   // Score the result channel first, then log the request accepted at the
   // same edge; a result can never belong to the request of its own edge.
   always @(posedge clock) begin : scoreboard
      pose_type got;
      pose_type want;
      pose_type model;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.smooth_x = rsp_smooth_x;
            got.smooth_y = rsp_smooth_y;
            got.smooth_z = rsp_smooth_z;
            got.delta_x  = rsp_delta_x;
            got.delta_y  = rsp_delta_y;
            got.delta_z  = rsp_delta_z;
            got.pitch    = rsp_pitch_angle;
            got.yaw      = rsp_yaw_angle;
            if (pending_poses.size() == 0) begin
               report_error("result arrived with no request pending");
            end else begin
               want = pending_poses.pop_front();
               check_field("smooth_x", got.smooth_x, want.smooth_x);
               check_field("smooth_y", got.smooth_y, want.smooth_y);
               check_field("smooth_z", got.smooth_z, want.smooth_z);
               check_field("delta_x", got.delta_x, want.delta_x);
               check_field("delta_y", got.delta_y, want.delta_y);
               check_field("delta_z", got.delta_z, want.delta_z);
               check_field("pitch_angle", got.pitch, want.pitch);
               check_field("yaw_angle", got.yaw, want.yaw);
            end
         end
         if (req_valid && !req_stall) begin
            // Always run the predictor so the history stays in step, even
            // when the row carries a hand-typed answer
            model = predict_pose(req_raw_x, req_raw_y, req_raw_z);
            pending_poses.push_back(pending_typed ? pending_want : model);
         end
      end
   end

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // Present one request after a random gap and hold it until accepted
   task automatic send_request(logic signed [16:0] rx, logic signed [16:0] ry,
                               logic signed [16:0] rz, bit typed, pose_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_x     <= rx;
      req_raw_y     <= ry;
      req_raw_z     <= rz;
      pending_typed = typed;
      pending_want  = want;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Drop valid, wait for every result, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_poses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: stall for a random number of cycles, then take one result
   initial begin : result_sink
      int hold;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do
            @(posedge clock);
         while (!(rsp_valid && !rsp_stall));
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   function automatic row_type item_row(int rx, int ry, int rz);
      row_type r;
      r      = '0;
      r.kind = ROW_ITEM;
      r.rx   = 17'(rx);
      r.ry   = 17'(ry);
      r.rz   = 17'(rz);
      return r;
   endfunction

   function automatic row_type typed_row(int rx, int ry, int rz, pose_type want);
      row_type r;
      r       = item_row(rx, ry, rz);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic row_type cfg_row(logic [CSR_IDX_W-1:0] idx, int value);
      row_type r;
      r      = '0;
      r.kind = ROW_CFG;
      r.idx  = idx;
      r.data = 16'(value);
      return r;
   endfunction

   // Mostly in-range positions, with full-width noise, values near the clamp,
   // tiny values around zero and exact zeros mixed in
   function automatic logic signed [16:0] pick_raw(int lim);
      logic signed [16:0] bits;
      int                 v;
      bits = 17'($urandom);
      case ($urandom_range(0, 9))
         0: v = int'(bits);
         1: begin
            v = lim - 50 + $urandom_range(0, 100);
            if ($urandom_range(0, 1))
               v = -v;
         end
         2: v = $urandom_range(0, 600) - 300;
         3: v = 0;
         default: v = $urandom_range(0, 2 * lim) - lim;
      endcase
      return 17'(v);
   endfunction

   function automatic logic [15:0] pick_offset();
      int v;
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 16'hFFFF);
         1: v = 25600;
         2: v = -25600;
         3: v = $urandom_range(0, 1) ? 32767 : -32768;
         4: v = 0;
         default: v = $urandom_range(0, 51200) - 25600;
      endcase
      return 16'(v);
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd256;
         2: return 16'(257 + $urandom_range(0, 254));
         3: return 16'($urandom);
         4: return 16'd1;
         5: return 16'd255;
         default: return 16'($urandom_range(0, 256));
      endcase
   endfunction

   initial begin : stimulus
      pose_type p;

      // Directed plan. Typed answers only where obvious: zero history with
      // zero gain or input gives all zeros, a unity-gain zero input only a delta.
      plan.push_back(typed_row(0, 0, 0, '0));
      plan.push_back(item_row(35000, 50000, 50000));
      plan.push_back(item_row(65535, 65535, 65535));
      plan.push_back(item_row(-65536, -65536, -65536));
      plan.push_back(item_row(-35000, -50000, -50000));
      // Unity gain flushes the history to the new sample
      plan.push_back(cfg_row(CSR_GAIN, 256));
      plan.push_back(item_row(0, 0, 0));
      // Zero gain holds the zero history whatever comes in
      plan.push_back(cfg_row(CSR_GAIN, 0));
      plan.push_back(typed_row(65535, -65536, -1, '0));
      plan.push_back(typed_row(-65536, 65535, 1, '0));
      // Gain past 256 saturates to unity
      plan.push_back(cfg_row(CSR_GAIN, 511));
      plan.push_back(item_row(35000, 0, 0));
      p         = '0;
      p.delta_x = -17'sd25600;
      plan.push_back(typed_row(0, 0, 0, p));
      // Left-half vectors, including the angle that wraps at pi
      plan.push_back(item_row(-35000, 0, 0));
      plan.push_back(item_row(-35000, 0, -50000));
      plan.push_back(item_row(-35000, 50000, 50000));
      plan.push_back(item_row(0, 50000, 0));
      plan.push_back(item_row(0, -50000, 0));
      // Offsets at and beyond +/-100 percent; the second clamp bounds the result
      plan.push_back(cfg_row(CSR_HOME_X, -32768));
      plan.push_back(cfg_row(CSR_HOME_Y, 32767));
      plan.push_back(cfg_row(CSR_HOME_Z, -25600));
      plan.push_back(item_row(35000, 50000, -50000));
      plan.push_back(item_row(-35000, -50000, 50000));
      plan.push_back(cfg_row(CSR_HOME_X, 25600));
      plan.push_back(cfg_row(CSR_HOME_Y, -25600));
      plan.push_back(cfg_row(CSR_HOME_Z, 25600));
      plan.push_back(cfg_row(CSR_GAIN, 1));
      plan.push_back(item_row(65535, 65535, 65535));
      // Tiny negatives truncate toward zero when scaled
      plan.push_back(item_row(-1, -1, -1));
      plan.push_back(item_row(1, 1, 1));
      plan.push_back(cfg_row(CSR_GAIN, 255));
      plan.push_back(item_row(34999, -49999, 2));
      plan.push_back(cfg_row(CSR_HOME_X, 0));
      plan.push_back(cfg_row(CSR_HOME_Y, 0));
      plan.push_back(cfg_row(CSR_HOME_Z, 0));
      plan.push_back(cfg_row(CSR_GAIN, int'(GAIN_RESET)));
      plan.push_back(item_row(17, -17, 3));

      // Hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CFG) begin
            wait_idle();
            write_register(plan[r].idx, plan[r].data);
         end else begin
            send_request(plan[r].rx, plan[r].ry, plan[r].rz, plan[r].typed, plan[r].want);
         end
      end

      // Random phases: fresh register settings, then a run of samples.
      // Some phases run with no idling on either side.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         write_register(CSR_HOME_X, pick_offset());
         write_register(CSR_HOME_Y, pick_offset());
         write_register(CSR_HOME_Z, pick_offset());
         write_register(CSR_GAIN, pick_gain());
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS)
            send_request(pick_raw(int'(X_LIMIT)), pick_raw(int'(YZ_LIMIT)),
                         pick_raw(int'(YZ_LIMIT)), 1'b0, '0);
      end

      // Drain every outstanding result and let the pipe go quiet
      no_idle = 1'b0;
      wait_idle();
      if (error_count == 0) begin
         $display("tb_three_axis_position_smoother: clean");
      end else begin
         $display("tb_three_axis_position_smoother: errors");
      end
      $finish;
   end

   // Watchdog: well past the slowest legal run
   initial begin : watchdog
      #1000000;
      $display("tb_three_axis_position_smoother: errors");
      $finish;
   end

endmodule
